// ===== rtl/cpu_pkg.sv =====
// shared constants, types and the cordic arc table for the camera pose update block
// no dependencies
`default_nettype none

package cpu_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int AXIS_W    = FRAC_BITS + 2;
    localparam int POS_W     = 32;
    localparam int DEG_W     = FRAC_BITS + 9;
    localparam int OFF_SH    = (FRAC_BITS >= 24) ? 0 : 24 - FRAC_BITS;
    localparam int RED_W     = DEG_W + OFF_SH + 2;
    localparam int RCNT_W    = $clog2(OFF_SH + 2);
    localparam int DV_W      = DEG_W + 24;
    localparam int TURN_W    = 32;
    localparam int QCNT_W    = $clog2(TURN_W);
    localparam int CW        = 34;
    localparam int CS        = 30 - FRAC_BITS;
    localparam int STEP_W    = $clog2(CORDIC_STEPS);
    localparam int ARC_IDX_W = 5;
    localparam int PR_W      = POS_W + AXIS_W;
    localparam int IN_W      = 3 * POS_W;
    localparam int USER_W    = 5;
    localparam int OUT_W     = ((3 * POS_W + 6 * AXIS_W + 7) / 8) * 8;

    localparam logic [DEG_W-1:0] FULL_CIRCLE = DEG_W'(360) << FRAC_BITS;
    localparam logic [RED_W-1:0] RED_OFFSET  = RED_W'(FULL_CIRCLE) << OFF_SH;
    localparam logic [DV_W-1:0]  TURN_DIV    = DV_W'(360) << (FRAC_BITS - 8);
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1 << FRAC_BITS);

    localparam logic [2:0] ACT_MOVE      = 3'd0;
    localparam logic [2:0] ACT_SET_POS   = 3'd1;
    localparam logic [2:0] ACT_SET_YAW   = 3'd2;
    localparam logic [2:0] ACT_SET_PITCH = 3'd3;
    localparam logic [2:0] ACT_ADD_YAW   = 3'd4;
    localparam logic [2:0] ACT_ADD_PITCH = 3'd5;

    localparam logic [1:0] AX_RIGHT = 2'd0;
    localparam logic [1:0] AX_UP    = 2'd1;
    localparam logic [1:0] AX_FWD   = 2'd2;

    typedef struct packed {
        logic                     done;
        logic signed [AXIS_W-1:0] sin_v;
        logic signed [AXIS_W-1:0] cos_v;
    } trig_t;

    function automatic logic [31:0] arc_lookup(input logic [ARC_IDX_W-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpu_sincos.sv =====
// sine and cosine of an angle in degrees: bit-serial turn division, then iterative cordic
// depends on cpu_pkg
`default_nettype none

module cpu_sincos import cpu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEG_W-1:0] deg,
    output trig_t            res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_QUAD = 5'b00100,
        S_ROT  = 5'b01000,
        S_FIN  = 5'b10000
    } sc_state_t;

    localparam logic signed [CW-1:0] C_ONE  = CW'(1 << FRAC_BITS);
    localparam logic signed [CW-1:0] C_MONE = -C_ONE;
    localparam logic signed [CW-1:0] C_HALF = CW'(1 << (CS - 1));

    sc_state_t state_reg, state_next;
    logic [DV_W-1:0] rem_reg, rem_next, dsr_reg, dsr_next;
    logic [TURN_W-1:0] q_reg, q_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic [1:0] quad_reg, quad_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [STEP_W-1:0] step_reg, step_next;
    trig_t res_reg, res_next;

    function automatic logic signed [AXIS_W-1:0] round_unit(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [AXIS_W-1:0] r;
        t = (v + C_HALF) >>> CS;
        if (t > C_ONE)
            r = AXIS_ONE;
        else if (t < C_MONE)
            r = -AXIS_ONE;
        else
            r = t[AXIS_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        logic ge;
        logic [TURN_W-1:0] tq, rb;
        logic [1:0] qd;
        logic signed [CW-1:0] dx, dy, arc;
        logic signed [AXIS_W-1:0] c, s;

        state_next = state_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        q_next     = q_reg;
        qcnt_next  = qcnt_reg;
        quad_next  = quad_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        res_next.done = 1'b0;

        ge  = rem_reg >= dsr_reg;
        tq  = q_reg + 32'h2000_0000;
        qd  = tq[TURN_W-1:TURN_W-2];
        rb  = q_reg - {qd, 30'd0};
        dx  = y_reg >>> step_reg;
        dy  = x_reg >>> step_reg;
        arc = $signed({2'b00, arc_lookup(ARC_IDX_W'(step_reg))});
        c   = round_unit(x_reg);
        s   = round_unit(y_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rem_next   = {deg, 24'd0};
                    dsr_next   = TURN_DIV << (TURN_W - 1);
                    qcnt_next  = QCNT_W'(TURN_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (ge)
                    rem_next = rem_reg - dsr_reg;
                q_next   = {q_reg[TURN_W-2:0], ge};
                dsr_next = dsr_reg >> 1;
                qcnt_next = qcnt_reg - 1'b1;
                if (qcnt_reg == '0)
                    state_next = S_QUAD;
            end
            S_QUAD:
            begin
                quad_next  = qd;
                z_next     = {{(CW-TURN_W){rb[TURN_W-1]}}, rb};
                x_next     = CORDIC_GAIN;
                y_next     = '0;
                step_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!z_reg[CW-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - arc;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + arc;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                res_next.done = 1'b1;
                case (quad_reg)
                    2'd0:
                    begin
                        res_next.cos_v = c;
                        res_next.sin_v = s;
                    end
                    2'd1:
                    begin
                        res_next.cos_v = -s;
                        res_next.sin_v = c;
                    end
                    2'd2:
                    begin
                        res_next.cos_v = -c;
                        res_next.sin_v = -s;
                    end
                    default:
                    begin
                        res_next.cos_v = s;
                        res_next.sin_v = -c;
                    end
                endcase
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        dsr_reg       <= dsr_next;
        q_reg         <= q_next;
        qcnt_reg      <= qcnt_next;
        quad_reg      <= quad_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        step_reg      <= step_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/camera_pose_update_core.sv =====
// camera pose update top level: position, yaw, pitch and look axes
// depends on cpu_pkg and cpu_sincos
// set position or unused action goes straight to the result; move does a product per axis;
// angle change does a modulo sweep, then per angle a turn division
// and a cordic, then two products
// one item at a time; the next item is taken once the result sits in the output register
// asynchronous active-low reset: position zero, angles zero, forward (0,0,-1), right (1,0,0)
`default_nettype none

module camera_pose_update_core import cpu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // value, value_y, value_z
    input  logic [USER_W-1:0] s_tuser,  // action, axis
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata   // pos_x/y/z, fwd_x/y/z, rgt_x/y/z, zero pad
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REDUCE = 7'b0000010,
        ST_TRIG_Y = 7'b0000100,
        ST_TRIG_P = 7'b0001000,
        ST_MUL    = 7'b0010000,
        ST_ACC    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } cpu_state_t;

    localparam logic signed [PR_W-1:0] P_ONE  = PR_W'(1 << FRAC_BITS);
    localparam logic signed [PR_W-1:0] P_MONE = -P_ONE;
    localparam logic signed [PR_W-1:0] P_HALF = PR_W'(1 << (FRAC_BITS - 1));

    cpu_state_t state_reg, state_next;
    logic [2:0] act_reg, act_next;
    logic [1:0] axis_reg, axis_next;
    logic signed [POS_W-1:0] val_reg, val_next;
    logic [RED_W-1:0] red_reg, red_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic [DEG_W-1:0] yaw_reg, yaw_next, pitch_reg, pitch_next;
    logic signed [AXIS_W-1:0] sy_reg, sy_next, cy_reg, cy_next;
    logic signed [AXIS_W-1:0] sp_reg, sp_next, cp_reg, cp_next;
    logic [1:0] k_reg, k_next;
    logic signed [PR_W-1:0] prod_reg, prod_next;
    logic signed [POS_W-1:0] pos_reg [3];
    logic signed [POS_W-1:0] pos_next [3];
    logic signed [AXIS_W-1:0] fwd_reg [3];
    logic signed [AXIS_W-1:0] fwd_next [3];
    logic signed [AXIS_W-1:0] rgt_reg [3];
    logic signed [AXIS_W-1:0] rgt_next [3];
    logic start_reg, start_next;
    logic mvalid_reg, mvalid_next;
    logic [OUT_W-1:0] mdata_reg, mdata_next;

    logic [2:0] in_act;
    logic [1:0] in_axis;
    logic signed [POS_W-1:0] in_v, in_vy, in_vz;
    logic in_take;
    trig_t trig;

    assign in_act  = s_tuser[2:0];
    assign in_axis = s_tuser[4:3];
    assign in_v    = s_tdata[POS_W-1:0];
    assign in_vy   = s_tdata[2*POS_W-1:POS_W];
    assign in_vz   = s_tdata[3*POS_W-1:2*POS_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;

    cpu_sincos u_sincos
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .deg   ((state_reg == ST_TRIG_P) ? pitch_reg : yaw_reg),
        .res   (trig)
    );

    always_comb
    begin
        logic [DEG_W-1:0] base;
        logic [RED_W-1:0] msh;
        logic to_yaw;
        logic signed [POS_W-1:0] op_a;
        logic signed [AXIS_W-1:0] op_b;
        logic signed [PR_W-1:0] rnd;
        logic signed [PR_W:0] sum;
        logic signed [AXIS_W-1:0] cl;

        state_next  = state_reg;
        act_next    = act_reg;
        axis_next   = axis_reg;
        val_next    = val_reg;
        red_next    = red_reg;
        rcnt_next   = rcnt_reg;
        yaw_next    = yaw_reg;
        pitch_next  = pitch_reg;
        sy_next     = sy_reg;
        cy_next     = cy_reg;
        sp_next     = sp_reg;
        cp_next     = cp_reg;
        k_next      = k_reg;
        prod_next   = prod_reg;
        pos_next    = pos_reg;
        fwd_next    = fwd_reg;
        rgt_next    = rgt_reg;
        start_next  = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;

        base = (in_act == ACT_ADD_YAW) ? yaw_reg :
               (in_act == ACT_ADD_PITCH) ? pitch_reg : '0;
        msh    = RED_W'(FULL_CIRCLE) << rcnt_reg;
        to_yaw = (act_reg == ACT_SET_YAW) || (act_reg == ACT_ADD_YAW);

        op_b = '0;
        if (act_reg == ACT_MOVE)
        begin
            op_a = val_reg;
            case (axis_reg)
                AX_RIGHT: op_b = rgt_reg[k_reg];
                AX_UP:    op_b = (k_reg == 2'd1) ? AXIS_ONE : '0;
                AX_FWD:   op_b = fwd_reg[k_reg];
                default:  op_b = '0;
            endcase
        end
        else
        begin
            op_a = (k_reg == 2'd0) ? POS_W'(sy_reg) : POS_W'(cy_reg);
            op_b = sp_reg;
        end

        rnd = (prod_reg + P_HALF) >>> FRAC_BITS;
        sum = PR_W'(rnd) + (PR_W+1)'(pos_reg[k_reg]);
        if (rnd > P_ONE)
            cl = AXIS_ONE;
        else if (rnd < P_MONE)
            cl = -AXIS_ONE;
        else
            cl = rnd[AXIS_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    act_next  = in_act;
                    axis_next = in_axis;
                    val_next  = in_v;
                    k_next    = '0;
                    unique case (in_act) inside
                        ACT_MOVE:
                        begin
                            state_next = ST_MUL;
                        end
                        ACT_SET_POS:
                        begin
                            pos_next[0] = in_v;
                            pos_next[1] = in_vy;
                            pos_next[2] = in_vz;
                            state_next  = ST_DONE;
                        end
                        ACT_SET_YAW, ACT_SET_PITCH, ACT_ADD_YAW, ACT_ADD_PITCH:
                        begin
                            red_next = {{(RED_W-POS_W){in_v[POS_W-1]}}, in_v}
                                       + RED_W'(base) + RED_OFFSET;
                            rcnt_next  = RCNT_W'(OFF_SH + 1);
                            state_next = ST_REDUCE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_REDUCE:
            begin
                if (red_reg >= msh)
                    red_next = red_reg - msh;
                rcnt_next = rcnt_reg - 1'b1;
                if (rcnt_reg == '0)
                begin
                    if (to_yaw)
                        yaw_next = red_next[DEG_W-1:0];
                    else
                        pitch_next = red_next[DEG_W-1:0];
                    start_next = 1'b1;
                    state_next = ST_TRIG_Y;
                end
            end
            ST_TRIG_Y:
            begin
                if (trig.done)
                begin
                    sy_next    = trig.sin_v;
                    cy_next    = trig.cos_v;
                    start_next = 1'b1;
                    state_next = ST_TRIG_P;
                end
            end
            ST_TRIG_P:
            begin
                if (trig.done)
                begin
                    sp_next    = trig.sin_v;
                    cp_next    = trig.cos_v;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = op_a * op_b;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (act_reg == ACT_MOVE)
                begin
                    if (sum[PR_W:POS_W-1] == '0 || sum[PR_W:POS_W-1] == '1)
                        pos_next[k_reg] = sum[POS_W-1:0];
                    else if (sum[PR_W])
                        pos_next[k_reg] = {1'b1, {(POS_W-1){1'b0}}};
                    else
                        pos_next[k_reg] = {1'b0, {(POS_W-1){1'b1}}};
                    k_next = k_reg + 1'b1;
                    state_next = (k_reg == 2'd2) ? ST_DONE : ST_MUL;
                end
                else if (k_reg == 2'd0)
                begin
                    fwd_next[0] = cl;
                    rgt_next[2] = cl;
                    k_next      = 2'd1;
                    state_next  = ST_MUL;
                end
                else
                begin
                    fwd_next[2] = cl;
                    rgt_next[0] = -cl;
                    fwd_next[1] = cp_reg;
                    rgt_next[1] = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = OUT_W'({rgt_reg[2], rgt_reg[1], rgt_reg[0],
                                          fwd_reg[2], fwd_reg[1], fwd_reg[0],
                                          pos_reg[2], pos_reg[1], pos_reg[0]});
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            start_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
            yaw_reg    <= '0;
            pitch_reg  <= '0;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= '0;
            fwd_reg[0] <= '0;
            fwd_reg[1] <= '0;
            fwd_reg[2] <= -AXIS_ONE;
            rgt_reg[0] <= AXIS_ONE;
            rgt_reg[1] <= '0;
            rgt_reg[2] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            start_reg  <= start_next;
            mvalid_reg <= mvalid_next;
            yaw_reg    <= yaw_next;
            pitch_reg  <= pitch_next;
            pos_reg    <= pos_next;
            fwd_reg    <= fwd_next;
            rgt_reg    <= rgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        axis_reg  <= axis_next;
        val_reg   <= val_next;
        red_reg   <= red_next;
        rcnt_reg  <= rcnt_next;
        sy_reg    <= sy_next;
        cy_reg    <= cy_next;
        sp_reg    <= sp_next;
        cp_reg    <= cp_next;
        k_reg     <= k_next;
        prod_reg  <= prod_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

`default_nettype wire

// ===== tb/camera_pose_update_core_test.sv =====
// testbench for camera_pose_update_core: random and directed camera updates
// predicts each result with an in-bench fixed-point pose model; depends on cpu_pkg
`timescale 1ns / 1ps

module camera_pose_update_core_test;
    import cpu_pkg::*;

    typedef struct {
        logic [2:0]         action;
        logic [1:0]         axis;
        logic signed [31:0] value;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } cam_item_t;

    typedef struct {
        logic signed [31:0]       pos [3];
        logic signed [AXIS_W-1:0] fwd [3];
        logic signed [AXIS_W-1:0] rgt [3];
    } pose_t;

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint CIRCLE = longint'(360) << FRAC_BITS;
    localparam int LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    cam_item_t pending_items[$];
    pose_t expected_poses[$];
    longint m_pos[3], m_fwd[3], m_rgt[3], m_yaw, m_pitch;
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    int s_hold = 0, m_hold = 0;

    camera_pose_update_core dut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint wrap_deg(longint a);
        longint r;
        r = a % CIRCLE;
        if (r < 0) r += CIRCLE;
        return r;
    endfunction

    function automatic longint sat_pos(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic trig(input longint deg, output longint sn, output longint cs);
        logic [31:0] turn, q, rb;
        longint x, y, z, dx, dy, c, s;
        logic [63:0] num, den;
        num = 64'(deg) << 24;
        den = 64'd360 << (FRAC_BITS - 8);
        turn = 32'(num / den);
        q = ((turn + 32'h20000000) >> 30) & 32'd3;
        rb = turn - (q << 30);
        z = longint'($signed(rb));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(arc_lookup(5'(i)));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(arc_lookup(5'(i)));
            end
        end
        c = unit_clamp(rshift(x, 30 - FRAC_BITS));
        s = unit_clamp(rshift(y, 30 - FRAC_BITS));
        case (q)
            0: begin cs = c; sn = s; end
            1: begin cs = -s; sn = c; end
            2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endtask

    task automatic rebuild_look();
        longint sy, cy, sp, cp;
        trig(m_yaw, sy, cy);
        trig(m_pitch, sp, cp);
        m_fwd[0] = unit_clamp(rshift(sy * sp, FRAC_BITS));
        m_fwd[1] = cp;
        m_fwd[2] = unit_clamp(rshift(cy * sp, FRAC_BITS));
        m_rgt[0] = -m_fwd[2];
        m_rgt[1] = 0;
        m_rgt[2] = m_fwd[0];
    endtask

    task automatic predict_pose(input cam_item_t it);
        longint v, comp;
        pose_t p;
        v = longint'(it.value);
        case (it.action)
            ACT_MOVE:
                for (int k = 0; k < 3; k++)
                begin
                    if (it.axis == AX_RIGHT) comp = m_rgt[k];
                    else if (it.axis == AX_UP) comp = (k == 1) ? ONE : 0;
                    else if (it.axis == AX_FWD) comp = m_fwd[k];
                    else comp = 0;
                    m_pos[k] = sat_pos(m_pos[k] + rshift(v * comp, FRAC_BITS));
                end
            ACT_SET_POS:
            begin
                m_pos[0] = v; m_pos[1] = it.value_y; m_pos[2] = it.value_z;
            end
            ACT_SET_YAW: begin m_yaw = wrap_deg(v); rebuild_look(); end
            ACT_SET_PITCH: begin m_pitch = wrap_deg(v); rebuild_look(); end
            ACT_ADD_YAW: begin m_yaw = wrap_deg(m_yaw + v); rebuild_look(); end
            ACT_ADD_PITCH: begin m_pitch = wrap_deg(m_pitch + v); rebuild_look(); end
            default: ;
        endcase
        for (int k = 0; k < 3; k++)
        begin
            p.pos[k] = 32'(m_pos[k]);
            p.fwd[k] = AXIS_W'(m_fwd[k]);
            p.rgt[k] = AXIS_W'(m_rgt[k]);
        end
        expected_poses.push_back(p);
    endtask

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return $signed(32'($urandom_range(0, 360)) << FRAC_BITS);
            1: return $signed($urandom_range(0, 720 * 65536)) - 360 * 65536;
            2: return $signed(32'($urandom_range(0, 7)) * 90 << FRAC_BITS);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic signed [31:0] rand_amount();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 2 * 65536 * 100)) - 65536 * 100;
            1: return $signed($urandom());
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic add_item(input logic [2:0] a, input logic [1:0] x,
                            input logic signed [31:0] v, input logic signed [31:0] vy,
                            input logic signed [31:0] vz);
        cam_item_t it;
        it.action = a; it.axis = x; it.value = v; it.value_y = vy; it.value_z = vz;
        pending_items.push_back(it);
    endtask

    initial
    begin
        cam_item_t it;
        m_pos = '{0, 0, 0};
        m_fwd = '{0, 0, -ONE};
        m_rgt = '{ONE, 0, 0};
        m_yaw = 0;
        m_pitch = 0;
        // reset axes before any angle change
        add_item(ACT_MOVE, AX_FWD, 32'sh00010000, 0, 0);
        add_item(ACT_MOVE, AX_RIGHT, 32'sh00020000, 0, 0);
        add_item(ACT_MOVE, AX_UP, 32'sh7fffffff, 0, 0);
        add_item(ACT_MOVE, AX_UP, 32'sh7fffffff, 0, 0);
        add_item(ACT_MOVE, 2'd3, 32'sh12345678, 0, 0);
        add_item(3'd6, 2'd0, 32'shffffffff, -1, -1);
        add_item(3'd7, 2'd3, 32'sh0, 0, 0);
        add_item(ACT_SET_POS, 2'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        add_item(ACT_MOVE, AX_UP, 32'sh7fffffff, 0, 0);
        add_item(ACT_MOVE, AX_FWD, 32'sh80000000, 0, 0);
        add_item(ACT_SET_YAW, 2'd0, 32'sh7fffffff, 0, 0);
        add_item(ACT_SET_YAW, 2'd0, 32'sh80000000, 0, 0);
        add_item(ACT_SET_PITCH, 2'd0, 32'sh005a0000, 0, 0);
        add_item(ACT_SET_PITCH, 2'd0, -32'sh005a0000, 0, 0);
        add_item(ACT_ADD_YAW, 2'd0, 32'sh01680000, 0, 0);
        add_item(ACT_ADD_YAW, 2'd0, -32'sh00010000, 0, 0);
        add_item(ACT_ADD_PITCH, 2'd0, 32'sh002d0000, 0, 0);
        add_item(ACT_ADD_PITCH, 2'd0, 32'sh80000000, 0, 0);
        add_item(ACT_MOVE, AX_RIGHT, 32'sh7fffffff, 0, 0);
        add_item(ACT_MOVE, AX_FWD, 32'sh7fffffff, 0, 0);
        add_item(ACT_SET_POS, 2'd0, 0, 0, 0);
        for (int n = 0; n < 1500; n++)
        begin
            it.action = 3'($urandom_range(0, 9));
            if (it.action > 3'd5 && $urandom_range(0, 3) != 0) it.action = ACT_MOVE;
            it.axis = 2'($urandom());
            if (it.axis == 2'd3 && $urandom_range(0, 3) != 0) it.axis = AX_FWD;
            it.value = (it.action >= ACT_SET_YAW && it.action <= ACT_ADD_PITCH)
                     ? rand_angle() : rand_amount();
            it.value_y = rand_amount();
            it.value_z = rand_amount();
            pending_items.push_back(it);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (s_tvalid) predict_pose(pending_items.pop_front());
                if (s_hold > 0) s_hold--;
                if (!quiet && s_hold == 0 && $urandom_range(0, 7) == 0)
                    s_hold = $urandom_range(1, 3);
                if (pending_items.size() != 0 && s_hold == 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_items[0].value_z, pending_items[0].value_y,
                                pending_items[0].value};
                    s_tuser <= {pending_items[0].axis, pending_items[0].action};
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (pending_items.size() < 200) quiet = 1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pose_t e;
        logic signed [31:0] gp;
        logic signed [AXIS_W-1:0] ga;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_poses.size() == 0)
                begin
                    $error("result with no expected pose");
                    errors++;
                end
                else
                begin
                    e = expected_poses.pop_front();
                    for (int k = 0; k < 3; k++)
                    begin
                        gp = m_tdata[32 * k +: 32];
                        if (gp !== e.pos[k])
                        begin
                            $error("pos[%0d] expected %0d got %0d", k, e.pos[k], gp);
                            errors++;
                        end
                        ga = m_tdata[96 + AXIS_W * k +: AXIS_W];
                        if (ga !== e.fwd[k])
                        begin
                            $error("fwd[%0d] expected %0d got %0d", k, e.fwd[k], ga);
                            errors++;
                        end
                        ga = m_tdata[96 + AXIS_W * (3 + k) +: AXIS_W];
                        if (ga !== e.rgt[k])
                        begin
                            $error("rgt[%0d] expected %0d got %0d", k, e.rgt[k], ga);
                            errors++;
                        end
                    end
                end
            end
            if (m_hold > 0) m_hold--;
            if (!quiet && m_hold == 0 && $urandom_range(0, 7) == 0)
                m_hold = $urandom_range(1, 3);
            m_tready <= (m_hold == 0);
        end
    end

    initial
    begin
        wait (rst_n);
        while ((pending_items.size() != 0 || s_tvalid || expected_poses.size() != 0)
               && cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_poses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
